[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the LED strip serializer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, off while reset is high
`define LCS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked on every edge
`define LCS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LCS_ASSERT(label, clk, rst, prop, msg)
`define LCS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/core/lcs_pkg.sv]
// ----------------------------------------------------------------------------
// lcs_pkg
// Types and constants for the LED strip chase serializer
// ----------------------------------------------------------------------------
package lcs_pkg;

  // strip size default
  localparam int NUM_LEDS_DEF = 64;

  // frame layout
  localparam int START_BITS = 32;
  localparam int LED_BITS   = 32;

  // colour store: led_index is 6 bits, so at most 64 entries are writable
  localparam int IDX_W       = 6;
  localparam int STORE_DEPTH = 64;
  localparam int COLOUR_W    = 8;
  localparam int ENTRY_W     = 3 * COLOUR_W;

  // brightness register
  localparam int               BRIGHT_W     = 5;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd15;

  // led frame header marker (top three bits of 0xE0)
  localparam logic [2:0] HDR_MARK = 3'b111;

  // item kinds carried on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // part of the refresh frame a bit belongs to
  typedef enum logic [1:0] {
    REG_START,
    REG_LED,
    REG_END
  } region_t;

  // per-tick decode handed from the sequencer to the bit stage
  typedef struct packed {
    logic       first;
    logic       last;
    region_t    region;
    logic       lit;
    logic [4:0] bit_idx;
  } tick_info_t;

endpackage

[rtl/core/lcs_store.sv]
// ----------------------------------------------------------------------------
// lcs_store
// Colour store: one write port, one registered read port, valid bits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcs_store
  import lcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld;
  logic [ENTRY_W-1:0]     rd_raw;
  logic                   rd_vld;

  // storage array, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // valid bits stand in for the reset clear of the array
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  // entry never written reads as black
  assign rd_data = rd_vld ? rd_raw : '0;

  `LCS_ASSERT(a_rw_exclusive, clk, rst, !(wr_en && rd_en), "store read and write in one cycle")
  `LCS_ASSERT(a_wr_sets_valid, clk, rst, wr_en |=> vld[$past(wr_addr)], "write left entry invalid")
  `LCS_ASSERT(a_rd_follows, clk, rst, (rd_en && vld[rd_addr]) |=> rd_vld, "read lost valid bit")

endmodule

[rtl/core/lcs_seq.sv]
// ----------------------------------------------------------------------------
// lcs_seq
// Bit and chase counters, per-tick frame decode and store read address
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcs_seq
  import lcs_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
)(
  input  logic             clk,
  input  logic             rst,
  input  logic             tick,
  output logic [IDX_W-1:0] rd_addr,
  output tick_info_t       info
);

  localparam int FRAME_BITS = START_BITS + (LED_BITS + 1) * NUM_LEDS;
  localparam int PW         = $clog2(FRAME_BITS);
  localparam int LW         = PW - 5;
  localparam int CW         = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  logic [PW-1:0] pos, pos_next;
  logic [CW-1:0] chase, chase_next;
  logic [PW-1:0] q;
  logic [LW-1:0] led;
  logic          in_start, in_led, chase_in_store;

  // decode of the current bit position
  always_comb begin
    q              = pos - PW'(START_BITS);
    led            = q[PW-1:5];
    in_start       = pos < PW'(START_BITS);
    in_led         = !in_start && (q < PW'(LED_BITS * NUM_LEDS));
    chase_in_store = 32'(chase) < STORE_DEPTH;

    info.first   = pos == '0;
    info.last    = pos == PW'(FRAME_BITS - 1);
    info.region  = in_start ? REG_START : (in_led ? REG_LED : REG_END);
    info.lit     = in_led && chase_in_store && (led == LW'(chase));
    info.bit_idx = q[4:0];
  end

  assign rd_addr = IDX_W'(chase);

  // counter advance on each tick
  always_comb begin
    pos_next   = pos;
    chase_next = chase;
    if (tick) begin
      if (info.last) begin
        pos_next   = '0;
        chase_next = (32'(chase) == NUM_LEDS - 1) ? '0 : chase + 1'b1;
      end else begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      chase <= '0;
    end else begin
      pos   <= pos_next;
      chase <= chase_next;
    end
  end

  `LCS_ASSERT(a_pos_range, clk, rst, pos <= PW'(FRAME_BITS - 1), "bit position past frame end")
  `LCS_ASSERT(a_chase_range, clk, rst, 32'(chase) < NUM_LEDS, "chase position past strip end")
  `LCS_ASSERT(a_chase_moves, clk, rst, (tick && info.last) |=> ((NUM_LEDS == 1) || (chase != $past(chase))), "chase did not advance at frame end")

endmodule

[rtl/core/led_strip_chase_serializer.sv]
// ----------------------------------------------------------------------------
// led_strip_chase_serializer
// APA102-style serial stream with a single lit LED chasing along the strip
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  s_*      in   tvalid/tready    tdata: led_index, red, green, blue
//                                 tuser: opcode (0 write, 1 tick)
//  m_*      out  tvalid/tready    tdata: data_bit; tuser: frame_first;
//                                 tlast: frame_last
//  cfg_*    in   cfg_we           cfg_wdata: brightness
//
//  One item per cycle while s_tready is high. A tick's bit is offered from the
//  output register after the store read into the bit stage. A write yields nothing.
//  The single store read port sets the rate: one entry per tick.
//  Reset (rst, synchronous) clears counters, valid bits and brightness to 15.
//  s_tready drops only when the bit stage and output register are both full
//  and m_tready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_strip_chase_serializer
  import lcs_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
)(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic [BRIGHT_W-1:0] cfg_wdata,
  // input items
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,   // led_index[5:0], red[13:6], green[21:14], blue[29:22]
  input  logic [0:0]          s_tuser,   // opcode[0]
  // result items
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // data_bit[0]
  output logic [0:0]          m_tuser,   // frame_first[0]
  output logic                m_tlast
);

  logic [BRIGHT_W-1:0] brightness;
  logic                s_acc, tick, wr;
  logic [IDX_W-1:0]    led_index, rd_addr;
  logic [COLOUR_W-1:0] red, green, blue;
  logic [ENTRY_W-1:0]  rd_data;
  tick_info_t          info, s1_info;
  logic                s1_valid, s1_adv;
  logic [31:0]         word;
  logic                bit_val;
  logic                out_valid, out_bit, out_first, out_last;

  // input unpacking
  assign led_index = s_tdata[5:0];
  assign red       = s_tdata[13:6];
  assign green     = s_tdata[21:14];
  assign blue      = s_tdata[29:22];

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign s_acc    = s_tvalid && s_tready;
  assign tick     = s_acc && (s_tuser[0] == OP_TICK);
  assign wr       = s_acc && (s_tuser[0] == OP_WRITE) && (32'(led_index) < NUM_LEDS);

  // brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHT_RESET;
    end else if (cfg_we) begin
      brightness <= cfg_wdata;
    end
  end

  lcs_seq #(
    .NUM_LEDS (NUM_LEDS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .rd_addr (rd_addr),
    .info    (info)
  );

  lcs_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr),
    .wr_addr (led_index),
    .wr_data ({red, green, blue}),
    .rd_en   (tick),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // bit stage: holds the tick while its store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_info <= info;
    end
  end

  // led word and bit select; rd_data is {red, green, blue}
  always_comb begin
    if (s1_info.lit && (rd_data != '0)) begin
      word = {HDR_MARK, brightness, rd_data[7:0], rd_data[15:8], rd_data[23:16]};
    end else begin
      word = {HDR_MARK, 29'd0};
    end
    case (s1_info.region)
      REG_START: bit_val = 1'b0;
      REG_LED:   bit_val = word[5'd31 - s1_info.bit_idx];
      REG_END:   bit_val = 1'b1;
      default:   bit_val = 1'b1;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bit   <= bit_val;
      out_first <= s1_info.first;
      out_last  <= s1_info.last;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {7'd0, out_bit};
  assign m_tuser[0] = out_first;
  assign m_tlast    = out_last;

  `LCS_ASSERT(a_tick_enters, clk, rst, tick |=> s1_valid, "accepted tick lost before bit stage")
  `LCS_ASSERT(a_full_stall, clk, rst, (s1_valid && out_valid && !m_tready) |-> !s_tready, "item taken while pipeline full")
  `LCS_ASSERT(a_first_last, clk, rst, m_tvalid |-> !(m_tuser[0] && m_tlast), "first and last marks on one item")

endmodule

[bench/tb_led_strip_chase_serializer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_strip_chase_serializer
// Self-checking bench for the serial LED stream with a single chasing lit LED.
// A bit-accurate predictor in a small scoreboard class tracks the colour store,
// the chase position and the frame bit position. Every tick item accepted adds
// one expected serial bit, and each output item is compared in order. The run
// has three parts. A short directed part comes first, then random mixed items
// with one long hold-off on the output. The last part runs with no idling.
// ----------------------------------------------------------------------------
module tb_led_strip_chase_serializer;
  import lcs_pkg::*;

  localparam int FRAME_LEN    = START_BITS + LED_BITS * NUM_LEDS_DEF + NUM_LEDS_DEF;
  localparam int PIPE_LAT     = 2;

  typedef struct packed {
    logic data_bit;
    logic first;
    logic last;
  } serial_bit_t;

  // predictor of the serial stream plus the queue of bits still due
  class strip_bit_predictor;
    logic [ENTRY_W-1:0]  colours [STORE_DEPTH];  // {red, green, blue}
    logic [IDX_W-1:0]    chase;
    int unsigned         bit_pos;
    logic [BRIGHT_W-1:0] brightness;
    int                  failures;
    serial_bit_t         expected_bits [$];

    function new();
      foreach (colours[i]) colours[i] = '0;
      chase       = '0;
      bit_pos     = 0;
      brightness  = BRIGHT_RESET;
      failures    = 0;
    endfunction

    // 32-bit word sent for one led: header, blue, green, red
    function logic [31:0] led_word(int unsigned led);
      logic [ENTRY_W-1:0] c;
      c = colours[led];
      if (led != chase || c == '0) return {HDR_MARK, 5'd0, 24'd0};
      return {HDR_MARK, brightness, c[7:0], c[15:8], c[23:16]};
    endfunction

    // note an accepted item: writes update the store, ticks add one bit
    function void note_item(logic op, logic [IDX_W-1:0] idx,
                            logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      serial_bit_t e;
      int unsigned q;
      logic [31:0] w;
      if (op == OP_WRITE) begin
        colours[idx] = {red, green, blue};
        return;
      end
      if (bit_pos < START_BITS) begin
        e.data_bit = 1'b0;
      end else if (bit_pos < START_BITS + LED_BITS * NUM_LEDS_DEF) begin
        q = bit_pos - START_BITS;
        w = led_word(q / LED_BITS);
        e.data_bit = w[LED_BITS - 1 - q % LED_BITS];
      end else begin
        e.data_bit = 1'b1;
      end
      e.first = (bit_pos == 0);
      e.last  = (bit_pos == FRAME_LEN - 1);
      expected_bits.push_back(e);
      bit_pos++;
      if (bit_pos == FRAME_LEN) begin
        bit_pos = 0;
        chase = (chase == NUM_LEDS_DEF - 1) ? '0 : chase + 1'b1;
      end
    endfunction

    // compare one output item with the oldest expected bit
    function void check_bit(serial_bit_t got);
      serial_bit_t want;
      if (expected_bits.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual data=%0b first=%0b last=%0b",
                 $time, got.data_bit, got.first, got.last);
        failures++;
        return;
      end
      want = expected_bits.pop_front();
      if (got.data_bit !== want.data_bit) begin
        $display("%0t: data_bit expected %0b actual %0b", $time, want.data_bit, got.data_bit);
        failures++;
      end
      if (got.first !== want.first) begin
        $display("%0t: frame_first expected %0b actual %0b", $time, want.first, got.first);
        failures++;
      end
      if (got.last !== want.last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [BRIGHT_W-1:0] cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata   = '0;  // led_index[5:0], red[13:6], green[21:14], blue[29:22]
  logic [0:0]          s_tuser   = '0;  // opcode[0]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [7:0]          m_tdata;         // data_bit[0]
  logic [0:0]          m_tuser;         // frame_first[0]
  logic                m_tlast;

  bit quiet    = 1'b0;  // no idling on either side
  bit hold_req = 1'b0;  // ask the sink for one long hold-off

  strip_bit_predictor pred = new();

  led_strip_chase_serializer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // colour value biased toward the extremes
  function automatic logic [7:0] pick_colour();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // offer one item and hold it until accepted, then maybe idle
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, blue, green, red, idx};
    do @(posedge clk); while (!s_tready);
    pred.note_item(op, idx, red, green, blue);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // tick with random noise in the unused fields
  task automatic send_tick();
    send_item(OP_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // stop offering and wait until every expected bit is out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pred.expected_bits.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [BRIGHT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred.brightness = value;
  endtask

  // output side: check items, random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    int hold_left;
    stall     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) pred.check_bit({m_tdata[0], m_tuser[0], m_tlast});
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int k;
    logic [IDX_W-1:0] idx;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: index and colour extremes, a black entry, first bits of a frame
    send_item(OP_WRITE, 6'd0,  8'hFF, 8'h00, 8'h01);
    send_item(OP_WRITE, 6'd63, 8'h00, 8'hFF, 8'h80);
    send_item(OP_WRITE, 6'd42, 8'hAA, 8'h55, 8'hFF);
    send_item(OP_WRITE, 6'd21, 8'h55, 8'hAA, 8'h7F);
    send_item(OP_WRITE, 6'd1,  8'h00, 8'h00, 8'h00);
    repeat (18) send_tick();
    drain();

    // random mixed items, sink holds off early so the input backs up
    set_brightness(5'($urandom));
    hold_req = 1'b1;
    for (k = 0; k < 600; k++) begin
      if ($urandom_range(0, 1)) begin
        send_tick();
      end else begin
        idx = ($urandom_range(0, 2) == 0) ? '0 : 6'($urandom);
        send_item(OP_WRITE, idx, pick_colour(), pick_colour(), pick_colour());
      end
    end
    drain();

    // closing part with no idling, full brightness, writes to the lit led
    set_brightness(5'd31);
    quiet = 1'b1;
    for (k = 0; k < 80; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        send_tick();
      end else begin
        idx = ($urandom_range(0, 1) == 0) ? pred.chase : 6'($urandom);
        send_item(OP_WRITE, idx, pick_colour(), pick_colour(), pick_colour());
      end
    end
    drain();

    if (pred.failures == 0) begin
      $display("[led_strip_chase_serializer] OK");
    end else begin
      $display("[led_strip_chase_serializer] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #50_000_000;
    $display("[led_strip_chase_serializer] ERROR");
    $finish;
  end

endmodule
